// ----- rtl/core/bba_pkg.sv -----
// shared types and constants of the bitmap block allocator
package bba_pkg;

  localparam int OP_W   = 2;
  localparam int BLK_W  = 11;
  localparam int BYTE_W = 8;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd2;
  localparam logic [OP_W-1:0] OP_READ    = 2'd3;

  localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hff;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BLK_W-1:0]  block_num;
    logic [BYTE_W-1:0] byte_index;
    logic [BYTE_W-1:0] byte_data;
  } bba_in_t;

  typedef struct packed {
    logic              status;
    logic [BLK_W-1:0]  alloc_block;
    logic [BYTE_W-1:0] read_byte;
  } bba_out_t;

endpackage

// ----- rtl/core/bitmap_block_allocator_core.sv -----
// top level of the bitmap first-fit block allocator
//
// Usage: one request word enters on in_* (valid/ready), one result word leaves
// on out_* (valid/ready) for every request. Ops: allocate, release a block,
// write a map byte, read a map byte.
// The used-block map lives in a single-port-write synchronous RAM of MAP_BYTES
// bytes; one bit per byte in flops marks the bytes that are all ones.
// Sequence: the block handles one request at a time. An allocate passes
// through S_SRCH, S_RD and S_WR from acceptance to the result register
// (full-mark group scan, group select and RAM read, read-modify-write), the
// other ops through S_RD and S_WR; the next request can be accepted the cycle
// after the result reaches the output register. The RAM read latency and the
// two-level full-mark priority encoder set these steps.
// Reset: after rst_n is released the RAM is swept to zero, one byte per cycle,
// for MAP_BYTES cycles; in_ready stays low during the sweep.
// Stall: if out_ready is low the finished result waits in the output register
// or a holding register; no new request is taken while it waits in the latter.
module bitmap_block_allocator_core #(
  parameter int MAP_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bba_pkg::bba_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bba_pkg::bba_out_t out_data
);

  localparam int AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int PW  = 13;
  localparam int GW  = 16;
  localparam int GIW = 4;
  localparam int NG  = (MAP_BYTES + GW - 1) / GW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);
  localparam logic [PW-1:0] MAP_LIMIT = PW'(MAP_BYTES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_PUSH  = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [AW-1:0]           clr_cnt_r;
  logic [MAP_BYTES-1:0]    fm_r;
  bba_pkg::bba_in_t        req_r;
  logic [AW-1:0]           pos_r;
  logic                    full_r;
  logic                    rng_r;
  logic [NG-1:0]           grp_ok_r;
  logic [GIW-1:0]          grp_idx_r [NG];
  logic [7:0]              rd_data_r;
  bba_pkg::bba_out_t       res_r;
  logic                    out_valid_r;
  bba_pkg::bba_out_t       out_data_r;

  logic [7:0]              map_mem [MAP_BYTES];

  logic [NG*GW-1:0]        fm_pad;
  logic [NG-1:0]           grp_ok;
  logic [GIW-1:0]          grp_idx [NG];
  logic                    srch_found;
  logic [PW-1:0]           srch_pos_w;
  logic [AW-1:0]           srch_pos;
  logic [7:0]              item_pos8;
  logic [PW-1:0]           item_pos_w;
  logic                    item_rng;
  logic [AW-1:0]           mem_ra;
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic [7:0]              mem_wd;
  logic [2:0]              free_bit;
  logic [7:0]              new_byte;
  logic                    upd_en;
  logic [PW+2:0]           grant_w;
  bba_pkg::bba_out_t       res;
  logic                    out_free;
  logic                    in_acc;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // first level of the full-mark search: lowest free byte inside each group
  always_comb begin
    fm_pad = '1;
    fm_pad[MAP_BYTES-1:0] = fm_r;
    for (int g = 0; g < NG; g++) begin
      grp_ok[g]  = 1'b0;
      grp_idx[g] = '0;
      for (int b = GW - 1; b >= 0; b--) begin
        if (!fm_pad[g*GW+b]) begin
          grp_ok[g]  = 1'b1;
          grp_idx[g] = GIW'(b);
        end
      end
    end
  end

  // second level: lowest group with a free byte
  always_comb begin
    srch_found = 1'b0;
    srch_pos_w = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_ok_r[g]) begin
        srch_found = 1'b1;
        srch_pos_w = (PW'(g) << GIW) | PW'(grp_idx_r[g]);
      end
    end
    srch_pos = srch_pos_w[AW-1:0];
  end

  always_comb begin
    item_pos8  = (req_r.op == bba_pkg::OP_RELEASE) ? req_r.block_num[10:3] : req_r.byte_index;
    item_pos_w = PW'(item_pos8);
    item_rng   = (item_pos_w < MAP_LIMIT);
    mem_ra     = (req_r.op == bba_pkg::OP_ALLOC) ? srch_pos : item_pos_w[AW-1:0];
  end

  // modify step on the byte read back from the map
  always_comb begin
    free_bit = 3'd7;
    for (int b = 6; b >= 0; b--) begin
      if (!rd_data_r[b]) begin
        free_bit = 3'(b);
      end
    end
    grant_w  = {PW'(pos_r), free_bit};
    new_byte = rd_data_r;
    upd_en   = 1'b0;
    res      = '0;
    unique case (req_r.op)
      bba_pkg::OP_ALLOC: begin
        if (full_r) begin
          res.status = 1'b1;
        end else begin
          new_byte        = rd_data_r | (8'd1 << free_bit);
          upd_en          = 1'b1;
          res.alloc_block = grant_w[bba_pkg::BLK_W-1:0];
        end
      end
      bba_pkg::OP_RELEASE: begin
        new_byte = rd_data_r & ~(8'd1 << req_r.block_num[2:0]);
        upd_en   = rng_r;
      end
      bba_pkg::OP_WRITE: begin
        new_byte = req_r.byte_data;
        upd_en   = rng_r;
      end
      bba_pkg::OP_READ: begin
        res.read_byte = rng_r ? rd_data_r : 8'd0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = pos_r;
    mem_wd = new_byte;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else if (state_r == S_WR) begin
      mem_we = upd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= map_mem[mem_ra];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: state_nxt = (clr_cnt_r == LAST_ADDR) ? S_IDLE : S_CLEAR;
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_data.op == bba_pkg::OP_ALLOC) ? S_SRCH : S_RD;
        end
      end
      S_SRCH:  state_nxt = S_RD;
      S_RD:    state_nxt = S_WR;
      S_WR:    state_nxt = out_free ? S_IDLE : S_PUSH;
      S_PUSH:  state_nxt = out_free ? S_IDLE : S_PUSH;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      fm_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (state_r == S_WR && upd_en) begin
        fm_r[pos_r] <= (new_byte == bba_pkg::FULL_BYTE);
      end
      if ((state_r == S_WR || state_r == S_PUSH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_data;
    end
    if (state_r == S_SRCH) begin
      grp_ok_r <= grp_ok;
      for (int g = 0; g < NG; g++) begin
        grp_idx_r[g] <= grp_idx[g];
      end
    end
    if (state_r == S_RD) begin
      pos_r  <= mem_ra;
      full_r <= (req_r.op == bba_pkg::OP_ALLOC) && !srch_found;
      rng_r  <= item_rng;
    end
    if (state_r == S_WR) begin
      res_r <= res;
      if (out_free) begin
        out_data_r <= res;
      end
    end else if (state_r == S_PUSH && out_free) begin
      out_data_r <= res_r;
    end
  end

endmodule

// ----- rtl/core/bba_chk.sv -----
// port-level checker for the block allocator, bound to the top level
module bba_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input bba_pkg::bba_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input bba_pkg::bba_out_t out_data
);

  // a held result word must not move
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in flight");

  // full report carries no block and no byte
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.alloc_block == 11'd0 &&
      out_data.read_byte == 8'd0)
    else $error("full status with nonzero payload");

  // a read byte never comes with a grant or a full report
  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_byte != 8'd0 |-> out_data.alloc_block == 11'd0 &&
      !out_data.status)
    else $error("read byte mixed with allocate result");

  // reset empties the output and holds off requests
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("port active right after reset");

endmodule

bind bitmap_block_allocator_core bba_chk u_bba_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- bench/bitmap_block_allocator_core_tb.sv -----
`timescale 1ns / 100ps
// self-checking bench of the bitmap block allocator core: directed and random words vs a predictor
module bitmap_block_allocator_core_tb;

  localparam int MAP_BYTES        = 256;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int DRAIN_CYCLES     = 30;
  localparam int RANDOM_PER_PHASE = 470;
  localparam int OP_W             = bba_pkg::OP_W;
  localparam int BLK_W            = bba_pkg::BLK_W;
  localparam int BYTE_W           = bba_pkg::BYTE_W;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  bba_pkg::bba_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  bba_pkg::bba_out_t out_data;

  int send_idle_pct = 21;
  int recv_idle_pct = 60;
  int err_count     = 0;
  int quiet_cycles  = 0;

  // predicted map contents and results still owed by the block
  logic [BYTE_W-1:0] used_bytes [MAP_BYTES];
  bba_pkg::bba_out_t expected_results [$];
  logic [BLK_W-1:0]  granted_blocks [$];

  bitmap_block_allocator_core #(
    .MAP_BYTES(MAP_BYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < MAP_BYTES; i++) used_bytes[i] = '0;
  end

  // predicts each op over the predicted map (first-fit allocation), updates it like the block does
  function automatic bba_pkg::bba_out_t allocator_result(input bba_pkg::bba_in_t w);
    bba_pkg::bba_out_t r;
    int                pos;
    int                bit_no;
    logic [BYTE_W-1:0] v;
    r = '0;
    case (w.op)
      bba_pkg::OP_ALLOC: begin
        pos = 0;
        while (pos < MAP_BYTES && used_bytes[pos] == bba_pkg::FULL_BYTE) pos++;
        if (pos >= MAP_BYTES) begin
          r.status = 1'b1;
        end else begin
          v = used_bytes[pos];
          bit_no = 0;
          while (bit_no < 7 && v[bit_no]) bit_no++;
          used_bytes[pos] = v | (8'd1 << bit_no);
          r.alloc_block = BLK_W'(pos * 8 + bit_no);
          granted_blocks.push_back(r.alloc_block);
        end
      end
      bba_pkg::OP_RELEASE: begin
        pos = int'(w.block_num >> 3);
        if (pos < MAP_BYTES) used_bytes[pos][w.block_num[2:0]] = 1'b0;
      end
      bba_pkg::OP_WRITE: begin
        if (int'(w.byte_index) < MAP_BYTES) used_bytes[w.byte_index] = w.byte_data;
      end
      default: begin
        if (int'(w.byte_index) < MAP_BYTES) r.read_byte = used_bytes[w.byte_index];
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // called and left at a falling edge; valid stays high across back-to-back words
  task automatic send_word(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk,
                           input logic [BYTE_W-1:0] idx, input logic [BYTE_W-1:0] data);
    bba_pkg::bba_in_t w;
    w.op         = op;
    w.block_num  = blk;
    w.byte_index = idx;
    w.byte_data  = data;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(allocator_result(w));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    bba_pkg::bba_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", int'(out_data), 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", int'(out_data.status), int'(want.status));
        if (out_data.alloc_block !== want.alloc_block)
          report_mismatch("alloc_block", int'(out_data.alloc_block), int'(want.alloc_block));
        if (out_data.read_byte !== want.read_byte)
          report_mismatch("read_byte", int'(out_data.read_byte), int'(want.read_byte));
      end
    end
  end

  // cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired at %0t", $realtime);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic test_directed;
    send_word(bba_pkg::OP_ALLOC, '0, '0, '0);
    send_word(bba_pkg::OP_ALLOC, 11'h7ff, 8'hff, 8'hff);
    send_word(bba_pkg::OP_ALLOC, '0, '0, '0);
    send_word(bba_pkg::OP_RELEASE, 11'd1, '0, '0);
    send_word(bba_pkg::OP_ALLOC, '0, '0, '0);
    // releasing a block that is already free
    send_word(bba_pkg::OP_RELEASE, 11'd5, '0, '0);
    send_word(bba_pkg::OP_READ, '0, 8'd0, '0);
    send_word(bba_pkg::OP_WRITE, '0, 8'd0, bba_pkg::FULL_BYTE);
    send_word(bba_pkg::OP_WRITE, '0, 8'hff, 8'h7f);
    send_word(bba_pkg::OP_ALLOC, '0, '0, '0);
    send_word(bba_pkg::OP_READ, '0, 8'hff, '0);
    send_word(bba_pkg::OP_RELEASE, 11'h7ff, '0, '0);
    send_word(bba_pkg::OP_WRITE, '0, 8'hff, bba_pkg::FULL_BYTE);
    send_word(bba_pkg::OP_READ, '0, 8'hff, '0);
    send_word(bba_pkg::OP_RELEASE, 11'h7ff, '0, '0);
    send_word(bba_pkg::OP_READ, '0, 8'hff, '0);
    send_word(bba_pkg::OP_WRITE, '0, 8'd0, 8'h00);
    send_word(bba_pkg::OP_READ, '0, 8'd0, '0);
    send_word(bba_pkg::OP_ALLOC, '0, '0, '0);
    send_word(bba_pkg::OP_WRITE, '0, 8'h55, 8'haa);
    send_word(bba_pkg::OP_READ, '0, 8'h55, '0);
    send_word(bba_pkg::OP_RELEASE, 11'h2aa, 8'haa, 8'h55);
    send_word(bba_pkg::OP_WRITE, '0, 8'haa, 8'h55);
    send_word(bba_pkg::OP_READ, 11'h555, 8'haa, '0);
    send_word(bba_pkg::OP_RELEASE, 11'h555, 8'h55, 8'haa);
  endtask

  task automatic test_map_full;
    for (int i = 0; i < MAP_BYTES; i++) begin
      send_word(bba_pkg::OP_WRITE, '0, i[7:0], bba_pkg::FULL_BYTE);
    end
    send_word(bba_pkg::OP_ALLOC, '0, '0, '0);
    send_word(bba_pkg::OP_READ, '0, 8'd128, '0);
    send_word(bba_pkg::OP_RELEASE, 11'd1027, '0, '0);
    send_word(bba_pkg::OP_ALLOC, '0, '0, '0);
    send_word(bba_pkg::OP_ALLOC, '0, '0, '0);
    send_word(bba_pkg::OP_RELEASE, 11'd0, '0, '0);
    send_word(bba_pkg::OP_RELEASE, 11'h7ff, '0, '0);
    send_word(bba_pkg::OP_ALLOC, '0, '0, '0);
    send_word(bba_pkg::OP_ALLOC, '0, '0, '0);
    send_word(bba_pkg::OP_ALLOC, '0, '0, '0);
    // reopen a few bytes so the random part starts near full
    for (int i = 0; i < 4; i++) send_word(bba_pkg::OP_WRITE, '0, 8'($urandom), 8'h00);
  endtask

  task automatic test_random(input int count);
    int                n;
    int                r;
    int                k;
    int                burst;
    logic [BLK_W-1:0]  blk;
    logic [BYTE_W-1:0] data;
    n = 0;
    while (n < count) begin
      r = $urandom_range(99);
      if (r < 5) begin
        burst = $urandom_range(40, 8);
        repeat (burst) begin
          send_word(bba_pkg::OP_ALLOC, BLK_W'($urandom), 8'($urandom), 8'($urandom));
        end
        n += burst;
      end else begin
        if (r < 40) begin
          send_word(bba_pkg::OP_ALLOC, BLK_W'($urandom), 8'($urandom), 8'($urandom));
        end else if (r < 60) begin
          // mostly hand back blocks that were granted earlier
          if (granted_blocks.size() != 0 && $urandom_range(9) < 7) begin
            k = $urandom_range(granted_blocks.size() - 1);
            blk = granted_blocks[k];
            granted_blocks.delete(k);
          end else begin
            blk = BLK_W'($urandom);
          end
          send_word(bba_pkg::OP_RELEASE, blk, 8'($urandom), 8'($urandom));
        end else if (r < 80) begin
          k = $urandom_range(9);
          if (k < 5) data = bba_pkg::FULL_BYTE;
          else if (k < 7) data = 8'h00;
          else data = 8'($urandom);
          send_word(bba_pkg::OP_WRITE, BLK_W'($urandom), 8'($urandom), data);
        end else begin
          send_word(bba_pkg::OP_READ, BLK_W'($urandom), 8'($urandom), 8'($urandom));
        end
        n++;
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_map_full();
    test_random(RANDOM_PER_PHASE);

    send_idle_pct = 60;
    recv_idle_pct = 21;
    test_random(RANDOM_PER_PHASE);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(RANDOM_PER_PHASE);

    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bba_pkg.sv
rtl/core/bitmap_block_allocator_core.sv
rtl/core/bba_chk.sv
bench/bitmap_block_allocator_core_tb.sv
